/* design/trr_pkg.sv */
`timescale 1ns / 1ps

package trr_pkg;

    // Panel geometry
    localparam int PANEL_WIDTH  = 240;
    localparam int PANEL_HEIGHT = 240;

    // Status byte decode
    localparam int         NEW_DATA_BIT = 7;
    localparam logic [3:0] COUNT_MIN    = 4'd1;
    localparam logic [3:0] COUNT_MAX    = 4'd5;

    // Register byte addresses
    localparam logic [3:0] ADDR_ROTATE_ENABLE = 4'h0;
    localparam logic [3:0] ADDR_ROT_COS       = 4'h4;
    localparam logic [3:0] ADDR_ROT_SIN       = 4'h8;

    // Register reset values
    localparam logic signed [15:0] ROT_COS_RESET = 16'sd16384;
    localparam logic signed [15:0] ROT_SIN_RESET = 16'sd0;

    // Arithmetic widths: doubled offsets, products, rotated sums
    localparam int OFS_W  = 18;
    localparam int COEF_W = 17;
    localparam int PROD_W = OFS_W + COEF_W;
    localparam int SUM_W  = PROD_W + 3;

    // Doubled centre scaled by 2^14
    localparam logic signed [SUM_W-1:0] CX_TERM = SUM_W'(PANEL_WIDTH * 16384);
    localparam logic signed [SUM_W-1:0] CY_TERM = SUM_W'(PANEL_HEIGHT * 16384);

    typedef struct packed {
        logic        status_ok;
        logic [7:0]  status_byte;
        logic        record_ok;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
    } report_t;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               pressed;
        logic               ack_status;
    } sample_t;

    typedef struct packed {
        logic               rotate_enable;
        logic signed [15:0] rot_cos;
        logic signed [15:0] rot_sin;
    } cfg_t;

    // Product stage contents
    typedef struct packed {
        logic signed [PROD_W-1:0] p_xc;
        logic signed [PROD_W-1:0] p_xs;
        logic signed [PROD_W-1:0] p_ys;
        logic signed [PROD_W-1:0] p_yc;
        logic [15:0]              mx;
        logic [15:0]              my;
        logic                     have;
        logic                     fresh;
    } prod_t;

endpackage

/* design/touch_report_rotate.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// report    in         report_valid/stall     report_t  (status, raw point)
// sample    out        sample_valid/stall     sample_t  (point, pressed, ack)
// config    in         APB psel/penable       rotate_enable, rot_cos, rot_sin
//
// One item per cycle sustained unless sample stalls. Items pass the input
// register, product register (four 18x17 multiplies), result register.
// Rounding, saturation and the held-point update sit in the last stage.
// Reset (rst_n low) empties the pipeline, centres the held point, and
// restores the registers. A stall on sample backs up stage by stage.

module touch_report_rotate (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             report_valid,
    output logic             report_stall,
    input  trr_pkg::report_t report,
    output logic             sample_valid,
    input  logic             sample_stall,
    output trr_pkg::sample_t sample
);
    import trr_pkg::*;

    cfg_t  cfg;
    prod_t prod;
    logic  prod_valid;
    logic  prod_ready;

    trr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trr_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .prod_valid   (prod_valid),
        .prod_ready   (prod_ready),
        .prod         (prod)
    );

    trr_fin u_fin (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .prod_valid   (prod_valid),
        .prod_ready   (prod_ready),
        .prod         (prod),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample)
    );

endmodule

/* design/trr_cfg.sv */
`timescale 1ns / 1ps

module trr_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output trr_pkg::cfg_t        cfg
);
    import trr_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotate_enable <= 1'b0;
            cfg_reg.rot_cos       <= ROT_COS_RESET;
            cfg_reg.rot_sin       <= ROT_SIN_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                ADDR_ROTATE_ENABLE: cfg_reg.rotate_enable <= pwdata[0];
                ADDR_ROT_COS:       cfg_reg.rot_cos       <= pwdata[15:0];
                ADDR_ROT_SIN:       cfg_reg.rot_sin       <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (paddr)
            ADDR_ROTATE_ENABLE: prdata = {31'd0, cfg_reg.rotate_enable};
            ADDR_ROT_COS:       prdata = {16'd0, cfg_reg.rot_cos};
            ADDR_ROT_SIN:       prdata = {16'd0, cfg_reg.rot_sin};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

/* design/trr_mul.sv */
`timescale 1ns / 1ps

module trr_mul (
    input  logic             clk,
    input  logic             rst_n,
    input  trr_pkg::cfg_t    cfg,
    input  logic             report_valid,
    output logic             report_stall,
    input  trr_pkg::report_t report,
    output logic             prod_valid,
    input  logic             prod_ready,
    output trr_pkg::prod_t   prod
);
    import trr_pkg::*;

    logic    a_valid_reg;
    report_t a_item_reg;
    logic    b_valid_reg;
    prod_t   b_reg;
    prod_t   b_next;

    logic a_ready;
    logic b_ready;

    logic                      fresh;
    logic [3:0]                cnt;
    logic [15:0]               mx;
    logic [15:0]               my;
    logic signed [OFS_W-1:0]   dx;
    logic signed [OFS_W-1:0]   dy;
    logic signed [COEF_W-1:0]  k_cos;
    logic signed [COEF_W-1:0]  k_sin;
    logic signed [COEF_W-1:0]  k_nsin;

    // stage readiness
    assign b_ready      = !b_valid_reg || prod_ready;
    assign a_ready      = !a_valid_reg || b_ready;
    assign report_stall = !a_ready;
    assign prod_valid   = b_valid_reg;
    assign prod         = b_reg;

    // decode, mirror and multiply
    always_comb
    begin
        fresh  = a_item_reg.status_ok && a_item_reg.status_byte[NEW_DATA_BIT];
        cnt    = a_item_reg.status_byte[3:0];
        mx     = 16'(PANEL_WIDTH - 1) - a_item_reg.raw_x;
        my     = 16'(PANEL_HEIGHT - 1) - a_item_reg.raw_y;
        dx     = $signed({mx[15], mx, 1'b0}) - $signed(OFS_W'(PANEL_WIDTH));
        dy     = $signed({my[15], my, 1'b0}) - $signed(OFS_W'(PANEL_HEIGHT));
        k_cos  = $signed({cfg.rot_cos[15], cfg.rot_cos});
        k_sin  = $signed({cfg.rot_sin[15], cfg.rot_sin});
        k_nsin = -k_sin;

        b_next.p_xc  = dx * k_cos;
        b_next.p_xs  = dy * k_nsin;
        b_next.p_ys  = dx * k_sin;
        b_next.p_yc  = dy * k_cos;
        b_next.mx    = mx;
        b_next.my    = my;
        b_next.fresh = fresh;
        b_next.have  = fresh && (cnt >= COUNT_MIN) && (cnt <= COUNT_MAX)
                       && a_item_reg.record_ok;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= report_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (a_ready && report_valid)
        begin
            a_item_reg <= report;
        end
        if (b_ready && a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

endmodule

/* design/trr_fin.sv */
`timescale 1ns / 1ps

module trr_fin (
    input  logic             clk,
    input  logic             rst_n,
    input  trr_pkg::cfg_t    cfg,
    input  logic             prod_valid,
    output logic             prod_ready,
    input  trr_pkg::prod_t   prod,
    output logic             sample_valid,
    input  logic             sample_stall,
    output trr_pkg::sample_t sample
);
    import trr_pkg::*;

    logic        out_valid_reg;
    sample_t     out_reg;
    sample_t     out_next;
    logic [15:0] held_x_reg;
    logic [15:0] held_y_reg;
    logic [15:0] held_x_next;
    logic [15:0] held_y_next;

    logic                    take;
    logic signed [SUM_W-1:0] num_x;
    logic signed [SUM_W-1:0] num_y;
    logic [15:0]             rx;
    logic [15:0]             ry;

    // value scaled by 2^15: round half away from zero, saturate to 16 bits
    function automatic logic [15:0] round_sat(input logic signed [SUM_W-1:0] num);
        logic                neg;
        logic [SUM_W-1:0]    mag;
        logic [SUM_W-16:0]   q;
        logic [SUM_W-1:0]    biased;
        logic [15:0]         res;
        neg    = num[SUM_W-1];
        mag    = neg ? SUM_W'(-num) : SUM_W'(num);
        biased = mag + SUM_W'(16384);
        q      = biased[SUM_W-1:15];
        if (neg)
        begin
            res = (q > (SUM_W-15)'(32768)) ? 16'h8000 : 16'(-q);
        end
        else
        begin
            res = (q > (SUM_W-15)'(32767)) ? 16'h7FFF : q[15:0];
        end
        return res;
    endfunction

    assign prod_ready   = !out_valid_reg || !sample_stall;
    assign take         = prod_valid && prod_ready;
    assign sample_valid = out_valid_reg;
    assign sample       = out_reg;

    // rotated sums and held-point update
    always_comb
    begin
        num_x = CX_TERM + SUM_W'(prod.p_xc) + SUM_W'(prod.p_xs);
        num_y = CY_TERM + SUM_W'(prod.p_ys) + SUM_W'(prod.p_yc);
        rx    = round_sat(num_x);
        ry    = round_sat(num_y);

        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        if (prod.have)
        begin
            held_x_next = cfg.rotate_enable ? rx : prod.mx;
            held_y_next = cfg.rotate_enable ? ry : prod.my;
        end

        out_next.point_x    = held_x_next;
        out_next.point_y    = held_y_next;
        out_next.pressed    = prod.have;
        out_next.ack_status = prod.fresh;
    end

    // control and held point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_x_reg    <= 16'(PANEL_WIDTH / 2);
            held_y_reg    <= 16'(PANEL_HEIGHT / 2);
        end
        else
        begin
            if (prod_ready)
            begin
                out_valid_reg <= prod_valid;
            end
            if (take)
            begin
                held_x_reg <= held_x_next;
                held_y_reg <= held_y_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

endmodule
